// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the quadrature decoder.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is applied.
`define DQD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define DQD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dqd_pkg.sv =====
// Shared types, constants and helper functions of the dual quadrature decoder.
// No dependencies.
package dqd_pkg;

  localparam int COUNT_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] TPR_RESET = 16'd1400;

  // 60 s/min * 1e6 us/s * 256 for the Q.8 fraction.
  localparam int          K_BITS    = 34;
  localparam logic [33:0] RPM_SCALE = 34'd15360000000;

  // ticks_per_rev times dt_us stays below 2^48.
  localparam int DEN_W = 48;

  typedef enum logic {
    ACT_SAMPLE  = 1'b0,
    ACT_MEASURE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic [31:0] dt_us;
  } entry_t;

  function automatic step_e step_of(input logic [1:0] last, input logic [1:0] now);
    case ({last, now})
      4'd2, 4'd4, 4'd11, 4'd13: return STEP_UP;
      4'd1, 4'd7, 4'd8, 4'd14:  return STEP_DOWN;
      default:                  return STEP_NONE;
    endcase
  endfunction

  function automatic logic [31:0] saturate(input logic [31:0] quo, input logic ovf,
                                           input logic neg);
    logic big;
    big = ovf | quo[31];
    if (neg) begin
      return big ? 32'h8000_0000 : (32'd0 - quo);
    end
    return big ? 32'h7FFF_FFFF : quo;
  endfunction

endpackage

// ===== src/dqd_ifs.sv =====
// Channel interfaces of the dual quadrature decoder: input items, results and
// the configuration write channel. No dependencies.
interface dqd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        left_a;
  logic        left_b;
  logic        right_a;
  logic        right_b;
  logic [31:0] dt_us;

  modport source (output valid, action, left_a, left_b, right_a, right_b, dt_us,
                  input ready);
  modport sink (input valid, action, left_a, left_b, right_a, right_b, dt_us,
                output ready);
endinterface

interface dqd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic signed [31:0] left_rpm;
  logic signed [31:0] right_rpm;

  modport source (output valid, left_count, right_count, left_rpm, right_rpm,
                  input ready);
  modport sink (input valid, left_count, right_count, left_rpm, right_rpm,
                output ready);
endinterface

interface dqd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] ticks_per_rev;

  modport source (output valid, ticks_per_rev, input ready);
  modport sink (input valid, ticks_per_rev, output ready);
endinterface

// ===== src/dqd_fifo.sv =====
// Small first-in first-out queue that decouples the decoder front from the
// speed back end. Depends on nothing but its parameters.
module dqd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/dqd_front.sv =====
// Front end: accepts beats, decodes the quadrature transitions, keeps the wheel
// counts and snapshots, and queues one entry per beat. Uses dqd_pkg.
module dqd_front
  import dqd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic                  left_a_i,
  input  logic                  left_b_i,
  input  logic                  right_a_i,
  input  logic                  right_b_i,
  input  logic [31:0]           dt_us_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output entry_t                entry_o,
  output logic [COUNT_BITS-1:0] dl_o,
  output logic [COUNT_BITS-1:0] dr_o
);

  logic [COUNT_BITS-1:0] lt_q, lt_d, rt_q, rt_d;
  logic [COUNT_BITS-1:0] ls_q, ls_d, rs_q, rs_d;
  logic [1:0]            lp_q, lp_d, rp_q, rp_d;
  logic                  loaded_q, loaded_d;
  logic [1:0]            lp_now, rp_now;
  logic                  accept;
  logic [COUNT_BITS+31:0] lext, rext;

  function automatic logic [COUNT_BITS-1:0] advance(input logic [COUNT_BITS-1:0] t,
                                                    input logic [1:0] last,
                                                    input logic [1:0] now);
    case (step_of(last, now))
      STEP_UP:   return t + COUNT_BITS'(1);
      STEP_DOWN: return t - COUNT_BITS'(1);
      default:   return t;
    endcase
  endfunction

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i & push_ready_i;
  assign push_valid_o = accept;
  assign lp_now       = {left_a_i, left_b_i};
  assign rp_now       = {right_a_i, right_b_i};

  always_comb begin
    lt_d     = lt_q;
    rt_d     = rt_q;
    ls_d     = ls_q;
    rs_d     = rs_q;
    lp_d     = lp_q;
    rp_d     = rp_q;
    loaded_d = loaded_q;
    if (accept) begin
      if (action_i == ACT_SAMPLE) begin
        lp_d = lp_now;
        rp_d = rp_now;
        if (!loaded_q) begin
          loaded_d = 1'b1;
        end else begin
          lt_d = advance(lt_q, lp_q, lp_now);
          rt_d = advance(rt_q, rp_q, rp_now);
        end
      end else begin
        ls_d = lt_q;
        rs_d = rt_q;
      end
    end
  end

  assign lext = {32'd0, lt_d};
  assign rext = {32'd0, rt_d};
  assign dl_o = lt_q - ls_q;
  assign dr_o = rt_q - rs_q;

  always_comb begin
    entry_o.action      = action_e'(action_i);
    entry_o.left_count  = lext[31:0];
    entry_o.right_count = rext[31:0];
    entry_o.dt_us       = dt_us_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q     <= '0;
      rt_q     <= '0;
      ls_q     <= '0;
      rs_q     <= '0;
      lp_q     <= '0;
      rp_q     <= '0;
      loaded_q <= 1'b0;
    end else begin
      lt_q     <= lt_d;
      rt_q     <= rt_d;
      ls_q     <= ls_d;
      rs_q     <= rs_d;
      lp_q     <= lp_d;
      rp_q     <= rp_d;
      loaded_q <= loaded_d;
    end
  end

endmodule

// ===== src/dqd_back.sv =====
// Back end: drains the queue, passes sample entries to the result register and
// runs the shift-add multiply and restoring divide for speed. Uses dqd_pkg.
module dqd_back
  import dqd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_o,
  input  entry_t                entry_i,
  input  logic [COUNT_BITS-1:0] dl_i,
  input  logic [COUNT_BITS-1:0] dr_i,
  input  logic [15:0]           tpr_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    left_count_o,
  output logic signed [31:0]    right_count_o,
  output logic signed [31:0]    left_rpm_o,
  output logic signed [31:0]    right_rpm_o
);

  localparam int NUM_W   = COUNT_BITS + K_BITS;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int K_IDX_W = $clog2(K_BITS);

  back_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  logic [COUNT_BITS-1:0] mag_l_q, mag_l_d, mag_r_q, mag_r_d;
  logic                  neg_l_q, neg_l_d, neg_r_q, neg_r_d;
  logic [NUM_W-1:0]      acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic [DEN_W-1:0]      rem_l_q, rem_l_d, rem_r_q, rem_r_d;
  logic [31:0]           quo_l_q, quo_l_d, quo_r_q, quo_r_d;
  logic                  ovf_l_q, ovf_l_d, ovf_r_q, ovf_r_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic [31:0]           plc_q, plc_d, prc_q, prc_d;
  logic [31:0]           olc_q, olc_d, orc_q, orc_d, olr_q, olr_d, orr_q, orr_d;

  logic                  out_free;
  logic                  scale_bit;
  logic [DEN_W:0]        sh_l, sh_r, dif_l, dif_r;
  logic                  ge_l, ge_r;

  assign out_free  = !out_valid_q || out_ready_i;
  assign scale_bit = RPM_SCALE[cnt_q[K_IDX_W-1:0]];

  assign sh_l  = {rem_l_q, acc_l_q[NUM_W-1]};
  assign sh_r  = {rem_r_q, acc_r_q[NUM_W-1]};
  assign dif_l = sh_l - {1'b0, den_q};
  assign dif_r = sh_r - {1'b0, den_q};
  assign ge_l  = (sh_l >= {1'b0, den_q});
  assign ge_r  = (sh_r >= {1'b0, den_q});

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    mag_l_d     = mag_l_q;
    mag_r_d     = mag_r_q;
    neg_l_d     = neg_l_q;
    neg_r_d     = neg_r_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    rem_l_d     = rem_l_q;
    rem_r_d     = rem_r_q;
    quo_l_d     = quo_l_q;
    quo_r_d     = quo_r_q;
    ovf_l_d     = ovf_l_q;
    ovf_r_d     = ovf_r_q;
    den_d       = den_q;
    plc_d       = plc_q;
    prc_d       = prc_q;
    olc_d       = olc_q;
    orc_d       = orc_q;
    olr_d       = olr_q;
    orr_d       = orr_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i && out_free) begin
          pop_o = 1'b1;
          if (entry_i.action == ACT_SAMPLE) begin
            out_valid_d = 1'b1;
            olc_d       = entry_i.left_count;
            orc_d       = entry_i.right_count;
            olr_d       = '0;
            orr_d       = '0;
          end else begin
            neg_l_d = dl_i[COUNT_BITS-1];
            neg_r_d = dr_i[COUNT_BITS-1];
            mag_l_d = dl_i[COUNT_BITS-1] ? (~dl_i + COUNT_BITS'(1)) : dl_i;
            mag_r_d = dr_i[COUNT_BITS-1] ? (~dr_i + COUNT_BITS'(1)) : dr_i;
            acc_l_d = '0;
            acc_r_d = '0;
            rem_l_d = '0;
            rem_r_d = '0;
            quo_l_d = '0;
            quo_r_d = '0;
            ovf_l_d = 1'b0;
            ovf_r_d = 1'b0;
            den_d   = DEN_W'(tpr_i) * DEN_W'(entry_i.dt_us);
            plc_d   = entry_i.left_count;
            prc_d   = entry_i.right_count;
            cnt_d   = CNT_W'(K_BITS - 1);
            state_d = B_MUL;
          end
        end
      end
      B_MUL: begin
        acc_l_d = {acc_l_q[NUM_W-2:0], 1'b0} + (scale_bit ? NUM_W'(mag_l_q) : '0);
        acc_r_d = {acc_r_q[NUM_W-2:0], 1'b0} + (scale_bit ? NUM_W'(mag_r_q) : '0);
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(NUM_W - 1);
          state_d = B_DIV;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      B_DIV: begin
        acc_l_d = {acc_l_q[NUM_W-2:0], 1'b0};
        acc_r_d = {acc_r_q[NUM_W-2:0], 1'b0};
        rem_l_d = ge_l ? dif_l[DEN_W-1:0] : sh_l[DEN_W-1:0];
        rem_r_d = ge_r ? dif_r[DEN_W-1:0] : sh_r[DEN_W-1:0];
        quo_l_d = {quo_l_q[30:0], ge_l};
        quo_r_d = {quo_r_q[30:0], ge_r};
        ovf_l_d = ovf_l_q | quo_l_q[31];
        ovf_r_d = ovf_r_q | quo_r_q[31];
        if (cnt_q == '0) begin
          state_d = B_OUT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          olc_d       = plc_q;
          orc_d       = prc_q;
          olr_d       = (den_q == '0) ? '0 : saturate(quo_l_q, ovf_l_q, neg_l_q);
          orr_d       = (den_q == '0) ? '0 : saturate(quo_r_q, ovf_r_q, neg_r_q);
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_l_q <= mag_l_d;
    mag_r_q <= mag_r_d;
    neg_l_q <= neg_l_d;
    neg_r_q <= neg_r_d;
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
    rem_l_q <= rem_l_d;
    rem_r_q <= rem_r_d;
    quo_l_q <= quo_l_d;
    quo_r_q <= quo_r_d;
    ovf_l_q <= ovf_l_d;
    ovf_r_q <= ovf_r_d;
    den_q   <= den_d;
    plc_q   <= plc_d;
    prc_q   <= prc_d;
    olc_q   <= olc_d;
    orc_q   <= orc_d;
    olr_q   <= olr_d;
    orr_q   <= orr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign left_count_o  = olc_q;
  assign right_count_o = orc_q;
  assign left_rpm_o    = olr_q;
  assign right_rpm_o   = orr_q;

endmodule

// ===== src/dual_quadrature_decoder_velocity_unit.sv =====
// Top level of the two-wheel x4 quadrature decoder with speed measurement.
// Uses dqd_pkg, the channel interfaces, dqd_front, dqd_fifo and dqd_back.
//
// Input beats carry either a pin sample of both encoders or a speed
// measurement with the elapsed microseconds. Every input beat gives exactly
// one result beat with both wheel counts and, for a measurement, both speeds
// in RPM as signed Q.8; a sample beat returns zero speeds.
// The front accepts one beat per cycle while the queue has room. A sample
// beat passes through the queue into the result register, so samples
// sustain one beat per cycle while the receiver keeps ready high. A
// measurement occupies the back end with a load step, 34 shift-add multiply
// steps, COUNT_BITS + 34 restoring divide steps and a result step; beats
// behind it wait in the queue.
// The configuration channel is always ready and takes ticks_per_rev; write it
// only while no beat is in flight.
// Reset clears the counts, snapshots and stored pin pairs, sets ticks_per_rev
// to 1400 and empties the queue; the first sample after reset only loads the
// pin pairs. When the receiver stalls, the result holds and the queue fills,
// after which input ready drops.
module dual_quadrature_decoder_velocity_unit
  import dqd_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dqd_in_if.sink   in_i,
  dqd_out_if.source out_o,
  dqd_cfg_if.sink  cfg_i
);

  localparam int Q_W = $bits(entry_t) + 2 * COUNT_BITS;

  logic [15:0]           tpr_q;
  logic                  push_valid;
  logic                  push_ready;
  entry_t                push_entry;
  logic [COUNT_BITS-1:0] push_dl, push_dr;
  logic [Q_W-1:0]        push_data;
  logic                  pop_valid;
  logic                  pop;
  logic [Q_W-1:0]        pop_data;
  entry_t                pop_entry;
  logic [COUNT_BITS-1:0] pop_dl, pop_dr;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q <= TPR_RESET;
    end else if (cfg_i.valid) begin
      tpr_q <= cfg_i.ticks_per_rev;
    end
  end

  dqd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .action_i     (in_i.action),
    .left_a_i     (in_i.left_a),
    .left_b_i     (in_i.left_b),
    .right_a_i    (in_i.right_a),
    .right_b_i    (in_i.right_b),
    .dt_us_i      (in_i.dt_us),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .entry_o      (push_entry),
    .dl_o         (push_dl),
    .dr_o         (push_dr)
  );

  assign push_data = {push_entry, push_dl, push_dr};

  dqd_fifo #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop),
    .pop_data_o   (pop_data)
  );

  assign {pop_entry, pop_dl, pop_dr} = pop_data;

  dqd_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .entry_i       (pop_entry),
    .dl_i          (pop_dl),
    .dr_i          (pop_dr),
    .tpr_i         (tpr_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .left_count_o  (out_o.left_count),
    .right_count_o (out_o.right_count),
    .left_rpm_o    (out_o.left_rpm),
    .right_rpm_o   (out_o.right_rpm)
  );

endmodule

// ===== src/dqd_checker.sv =====
// Port-level checker for the dual quadrature decoder, bound to the top level.
// Uses the macros of assert_macros.svh.
`include "assert_macros.svh"

module dqd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] left_count_i,
  input logic [31:0] right_count_i,
  input logic [31:0] left_rpm_i,
  input logic [31:0] right_rpm_i
);

  logic [7:0]   pending_q;
  logic         in_beat;
  logic         out_beat;
  logic         pending;
  logic         out_stall;
  logic [127:0] payload;

  assign in_beat   = in_valid_i & in_ready_i;
  assign out_beat  = out_valid_i & out_ready_i;
  assign pending   = (pending_q != 8'd0);
  assign out_stall = out_valid_i & !out_ready_i;
  assign payload   = {left_count_i, right_count_i, left_rpm_i, right_rpm_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_beat) - 8'(out_beat);
    end
  end

  `DQD_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "result beat during reset")
  `DQD_ASSERT(a_no_extra_beat, clk_i, rst_ni, out_valid_i |-> pending, "result beat without input beat")
  `DQD_ASSERT(a_valid_holds, clk_i, rst_ni, out_stall |=> out_valid_i, "result dropped while stalled")
  `DQD_ASSERT(a_payload_holds, clk_i, rst_ni, out_stall |=> $stable(payload), "result changed while stalled")

endmodule

bind dual_quadrature_decoder_velocity_unit dqd_checker u_dqd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .left_count_i  (out_o.left_count),
  .right_count_i (out_o.right_count),
  .left_rpm_i    (out_o.left_rpm),
  .right_rpm_i   (out_o.right_rpm)
);
